### design/fpp_pkg.sv
// Package for the fee priority pool: sizes, codes and transfer structs.
// Used by fpp_cell, fpp_chain and fee_priority_pool_top; depends on nothing.
package fpp_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int BLOCK_TX   = 16;

  localparam int FEE_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int HELD_W   = 7;
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
  localparam int LEFT_W   = $clog2(BLOCK_TX + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_TAKE   = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    STATUS_INSERTED = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_BADSIG   = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_TAKEN    = 3'd4,
    STATUS_FLUSHED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_TAKE
  } state_e;

  typedef struct packed {
    logic [FEE_W-1:0]    fee;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } chain_ctl_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [FEE_W-1:0]    fee;
    logic [HANDLE_W-1:0] entry_handle;
    logic                sig_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [FEE_W-1:0]    out_fee;
    logic                last;
    logic [HELD_W-1:0]   held_count;
  } out_item_t;

endpackage

### design/fee_priority_pool_top.sv
// Fee priority pool: insert, flush and rejected requests give one result in the cycle
// after the input transfer, and such requests can follow one per cycle while the receiver
// does not stall. A take gives min(held, BLOCK_TX) results: the first once the state has
// moved to take, then one per cycle while the output is free, paced by the one-slot shift
// of the cell chain. The input stays stalled until the last result of a take is loaded.
// Reset clears the state, the held count and the output valid flag; slots are not cleared.
module fee_priority_pool_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fpp_pkg::out_item_t out_data_o
);

  fpp_pkg::state_e           state_q, state_d;
  logic [fpp_pkg::CNT_W-1:0]  count_q, count_d;
  logic [fpp_pkg::LEFT_W-1:0] left_q, left_d;
  logic                       out_valid_q, out_valid_d;
  fpp_pkg::out_item_t         out_q, out_d;
  logic                       load_out;
  logic                       out_free;
  logic                       in_acc;
  fpp_pkg::chain_ctl_t        ctl;
  fpp_pkg::entry_t            head;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != fpp_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  fpp_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .count_i (count_q),
    .head_o  (head)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpp_pkg::ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == fpp_pkg::REQ_TAKE) && (count_q != '0)) begin
          state_d = fpp_pkg::ST_TAKE;
        end
      end
      fpp_pkg::ST_TAKE: begin
        if (out_free && (left_q == fpp_pkg::LEFT_W'(1))) begin
          state_d = fpp_pkg::ST_IDLE;
        end
      end
      default: state_d = fpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op        = fpp_pkg::OP_HOLD;
    ctl.new_entry = '{fee: in_data_i.fee, handle: in_data_i.entry_handle};
    count_d       = count_q;
    left_d        = left_q;
    load_out      = 1'b0;
    out_d         = out_q;
    out_d.out_handle = '0;
    out_d.out_fee    = '0;
    out_d.last       = 1'b1;
    out_d.held_count = fpp_pkg::HELD_W'(count_q);

    unique case (state_q)
      fpp_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.req_type)
            fpp_pkg::REQ_INSERT: begin
              load_out = 1'b1;
              if (count_q == fpp_pkg::CNT_W'(fpp_pkg::POOL_DEPTH)) begin
                out_d.status = fpp_pkg::STATUS_FULL;
              end else if (!in_data_i.sig_valid) begin
                out_d.status = fpp_pkg::STATUS_BADSIG;
              end else begin
                ctl.op           = fpp_pkg::OP_INSERT;
                count_d          = count_q + fpp_pkg::CNT_W'(1);
                out_d.status     = fpp_pkg::STATUS_INSERTED;
                out_d.held_count = fpp_pkg::HELD_W'(count_d);
              end
            end
            fpp_pkg::REQ_TAKE: begin
              if (count_q == '0) begin
                load_out     = 1'b1;
                out_d.status = fpp_pkg::STATUS_EMPTY;
              end else if (32'(count_q) >= 32'(fpp_pkg::BLOCK_TX)) begin
                left_d = fpp_pkg::LEFT_W'(fpp_pkg::BLOCK_TX);
              end else begin
                left_d = fpp_pkg::LEFT_W'(count_q);
              end
            end
            fpp_pkg::REQ_FLUSH: begin
              load_out         = 1'b1;
              count_d          = '0;
              out_d.status     = fpp_pkg::STATUS_FLUSHED;
              out_d.held_count = '0;
            end
            default: ;
          endcase
        end
      end
      fpp_pkg::ST_TAKE: begin
        if (out_free) begin
          // Emit the head and move every slot one place toward the head.
          load_out         = 1'b1;
          ctl.op           = fpp_pkg::OP_SHIFT;
          count_d          = count_q - fpp_pkg::CNT_W'(1);
          left_d           = left_q - fpp_pkg::LEFT_W'(1);
          out_d.status     = fpp_pkg::STATUS_TAKEN;
          out_d.out_handle = head.handle;
          out_d.out_fee    = head.fee;
          out_d.last       = (left_q == fpp_pkg::LEFT_W'(1));
          out_d.held_count = fpp_pkg::HELD_W'(count_d);
        end
      end
      default: ;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpp_pkg::ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/fpp_cell.sv
// One slot of the sorted pool: holds a fee and handle, takes part in insert and shift.
// Depends on fpp_pkg.
module fpp_cell (
  input  logic                clk_i,
  input  fpp_pkg::chain_ctl_t ctl_i,
  input  logic                occ_i,
  input  logic                prev_keep_i,
  input  fpp_pkg::entry_t     left_i,
  input  fpp_pkg::entry_t     right_i,
  output logic                keep_o,
  output fpp_pkg::entry_t     entry_o
);

  fpp_pkg::entry_t entry_q, entry_d;

  // An occupied slot whose fee is at least the new one stays where it is.
  assign keep_o = occ_i && (entry_q.fee >= ctl_i.new_entry.fee);

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      fpp_pkg::OP_INSERT: begin
        if (keep_o) begin
          entry_d = entry_q;
        end else if (prev_keep_i) begin
          entry_d = ctl_i.new_entry;
        end else begin
          entry_d = left_i;
        end
      end
      fpp_pkg::OP_SHIFT: entry_d = right_i;
      default:           entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### design/fpp_chain.sv
// Row of POOL_DEPTH cells kept in descending fee order, head at slot zero.
// Depends on fpp_pkg and fpp_cell.
module fpp_chain (
  input  logic                      clk_i,
  input  fpp_pkg::chain_ctl_t       ctl_i,
  input  logic [fpp_pkg::CNT_W-1:0] count_i,
  output fpp_pkg::entry_t           head_o
);

  fpp_pkg::entry_t entries [fpp_pkg::POOL_DEPTH];
  logic [fpp_pkg::POOL_DEPTH-1:0] keep;

  for (genvar i = 0; i < fpp_pkg::POOL_DEPTH; i++) begin : g_cell
    logic            occ;
    logic            prev_keep;
    fpp_pkg::entry_t left;
    fpp_pkg::entry_t right;

    assign occ = (count_i > fpp_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign left      = ctl_i.new_entry;
    end else begin : g_inner
      assign prev_keep = keep[i-1];
      assign left      = entries[i-1];
    end

    // The tail slot has no right neighbor; what it takes on a shift is never read.
    if (i == fpp_pkg::POOL_DEPTH - 1) begin : g_tail
      assign right = entries[i];
    end else begin : g_body
      assign right = entries[i+1];
    end

    fpp_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .occ_i       (occ),
      .prev_keep_i (prev_keep),
      .left_i      (left),
      .right_i     (right),
      .keep_o      (keep[i]),
      .entry_o     (entries[i])
    );
  end

  assign head_o = entries[0];

endmodule

### test/tb_top.sv
// Self-checking testbench for fee_priority_pool_top: a queue-fed driver, a random receiver
// and an internal model of the fee-ordered pool that predicts every result transfer.
// Depends on fpp_pkg and the fee_priority_pool_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 330;
  localparam int CALM_TAIL    = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  fpp_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  fpp_pkg::out_item_t out_data_o;

  fee_priority_pool_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Pool model: fees highest first, handles alongside.
  logic [fpp_pkg::FEE_W-1:0]    pool_fee    [fpp_pkg::POOL_DEPTH];
  logic [fpp_pkg::HANDLE_W-1:0] pool_handle [fpp_pkg::POOL_DEPTH];
  int                           pool_count;

  fpp_pkg::in_item_t  pending_reqs [$];
  fpp_pkg::out_item_t expected_results [$];
  fpp_pkg::out_item_t want;

  bit in_taken;
  bit long_hold;
  int in_gap;
  int out_gap;
  int in_count;
  int results_seen;
  int mismatches;
  int full_rejects;
  int badsig_rejects;
  int blocks_taken;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_seen, name, got, exp_val));
  endtask

  function automatic void push_result(fpp_pkg::status_e st,
                                      logic [fpp_pkg::HANDLE_W-1:0] handle,
                                      logic [fpp_pkg::FEE_W-1:0] fee, logic lst, int held);
    fpp_pkg::out_item_t res;
    res.status     = st;
    res.out_handle = handle;
    res.out_fee    = fee;
    res.last       = lst;
    res.held_count = held[fpp_pkg::HELD_W-1:0];
    expected_results.push_back(res);
  endfunction

  // Updates the pool model with one accepted request and queues its results.
  function automatic void apply_request(fpp_pkg::in_item_t req);
    int pos;
    int n;
    case (req.req_type)
      fpp_pkg::REQ_INSERT: begin
        if (pool_count >= fpp_pkg::POOL_DEPTH) begin
          full_rejects++;
          push_result(fpp_pkg::STATUS_FULL, '0, '0, 1'b1, pool_count);
        end else if (!req.sig_valid) begin
          badsig_rejects++;
          push_result(fpp_pkg::STATUS_BADSIG, '0, '0, 1'b1, pool_count);
        end else begin
          // The new entry lands in front of the first strictly lower fee.
          pos = pool_count;
          for (int i = pool_count - 1; i >= 0; i--)
            if (pool_fee[i] < req.fee) pos = i;
          for (int i = pool_count; i > pos; i--) begin
            pool_fee[i]    = pool_fee[i-1];
            pool_handle[i] = pool_handle[i-1];
          end
          pool_fee[pos]    = req.fee;
          pool_handle[pos] = req.entry_handle;
          pool_count++;
          push_result(fpp_pkg::STATUS_INSERTED, '0, '0, 1'b1, pool_count);
        end
      end
      fpp_pkg::REQ_TAKE: begin
        if (pool_count == 0) begin
          push_result(fpp_pkg::STATUS_EMPTY, '0, '0, 1'b1, 0);
        end else begin
          blocks_taken++;
          n = (pool_count < fpp_pkg::BLOCK_TX) ? pool_count : fpp_pkg::BLOCK_TX;
          for (int i = 0; i < n; i++)
            push_result(fpp_pkg::STATUS_TAKEN, pool_handle[i], pool_fee[i], i == n - 1,
                        pool_count - i - 1);
          for (int i = n; i < pool_count; i++) begin
            pool_fee[i-n]    = pool_fee[i];
            pool_handle[i-n] = pool_handle[i];
          end
          pool_count -= n;
        end
      end
      fpp_pkg::REQ_FLUSH: begin
        pool_count = 0;
        push_result(fpp_pkg::STATUS_FLUSHED, '0, '0, 1'b1, 0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] kind, logic [fpp_pkg::FEE_W-1:0] fee,
                                    logic [fpp_pkg::HANDLE_W-1:0] handle, logic sig);
    fpp_pkg::in_item_t req;
    req.req_type     = kind;
    req.fee          = fee;
    req.entry_handle = handle;
    req.sig_valid    = sig;
    pending_reqs.push_back(req);
  endfunction

  // Small and clustered fees give many ties; the rest spread over the full range.
  function automatic logic [fpp_pkg::FEE_W-1:0] pick_fee();
    case ($urandom_range(0, 5))
      0:       pick_fee = $urandom_range(0, 7);
      1:       pick_fee = 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       pick_fee = $urandom_range(1000, 1020);
      default: pick_fee = $urandom();
    endcase
  endfunction

  // Idling is switched off in the tail of the run and in every third stretch of 40 transfers.
  function automatic bit idling_on();
    return pending_reqs.size() >= CALM_TAIL && ((in_count / 40) % 3 != 1);
  endfunction

  // Result check first, then the input transfer of the same edge.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", out_data_o.status));
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(out_data_o.status), 32'(want.status));
        check_field("out_handle", out_data_o.out_handle, want.out_handle);
        check_field("out_fee", out_data_o.out_fee, want.out_fee);
        check_field("last", 32'(out_data_o.last), 32'(want.last));
        check_field("held_count", 32'(out_data_o.held_count), 32'(want.held_count));
      end
      results_seen++;
    end
    if (in_valid_i && !in_stall_o) begin
      apply_request(in_data_i);
      void'(pending_reqs.pop_front());
      in_count++;
      in_taken = 1'b1;
    end
  end

  // Sender: holds an offered item until its transfer, then may pause.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
        if (idling_on() && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, overridden by the long hold.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) out_gap--;
      else if (idling_on() && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 13);
      out_stall_i <= long_hold || (out_gap > 0);
    end
  end

  // Long receiver hold-off while requests keep coming, so the pool backs up to its input.
  initial begin
    long_hold = 1'b0;
    wait (in_count >= 100);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int kind;
    int len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    pool_count  = 0;

    // Directed: empty pool, extreme fees and handles, bad signature, equal fees, unknown type.
    queue_req(fpp_pkg::REQ_TAKE, 32'd5, 32'd5, 1'b1);
    queue_req(fpp_pkg::REQ_FLUSH, '0, '0, 1'b0);
    queue_req(fpp_pkg::REQ_INSERT, 32'd0, 32'd0, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'd1000, 32'hAAAA_5555, 1'b0);
    queue_req(fpp_pkg::REQ_INSERT, 32'd1000, 32'd1, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'd1000, 32'd2, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'd1000, 32'd3, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'd0, 32'd4, 1'b1);
    queue_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'd5000, 32'd5, 1'b1);
    queue_req(fpp_pkg::REQ_TAKE, 32'hFFFF_FFFF, 32'd9, 1'b0);
    queue_req(fpp_pkg::REQ_TAKE, '0, '0, 1'b0);
    queue_req(fpp_pkg::REQ_INSERT, 32'd7, 32'd6, 1'b1);
    queue_req(fpp_pkg::REQ_FLUSH, 32'h1234_5678, 32'h8765_4321, 1'b1);
    queue_req(fpp_pkg::REQ_TAKE, '0, '0, 1'b1);
    queue_req(REQ_UNKNOWN, '0, '0, 1'b0);
    queue_req(fpp_pkg::REQ_INSERT, 32'h8000_0000, 32'h5555_AAAA, 1'b1);
    queue_req(fpp_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    queue_req(fpp_pkg::REQ_TAKE, '0, '0, 1'b0);
    queue_req(fpp_pkg::REQ_FLUSH, '0, '0, 1'b0);

    // Random: an opening fill that runs past full, then fills, drains and mixed traffic.
    for (int i = 0; i < fpp_pkg::POOL_DEPTH + 6; i++)
      queue_req(fpp_pkg::REQ_INSERT, pick_fee(), $urandom(), i < fpp_pkg::POOL_DEPTH + 3);
    queue_req(fpp_pkg::REQ_TAKE, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    while (pending_reqs.size() < RANDOM_ITEMS - 20) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        len = $urandom_range(10, 40);
        repeat (len)
          queue_req(fpp_pkg::REQ_INSERT, pick_fee(), $urandom(),
                    $urandom_range(0, 15) != 0);
      end else if (kind < 6) begin
        repeat ($urandom_range(1, 3))
          queue_req(fpp_pkg::REQ_TAKE, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
      end else if (kind < 9) begin
        len = $urandom_range(3, 12);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: queue_req(fpp_pkg::REQ_INSERT, pick_fee(), $urandom(),
                                        $urandom_range(0, 5) != 0);
            6, 7:    queue_req(fpp_pkg::REQ_TAKE, $urandom(), $urandom(),
                               1'($urandom_range(0, 1)));
            8:       queue_req(fpp_pkg::REQ_FLUSH, $urandom(), $urandom(),
                               1'($urandom_range(0, 1)));
            default: queue_req(REQ_UNKNOWN, $urandom(), $urandom(),
                               1'($urandom_range(0, 1)));
          endcase
        end
      end else begin
        queue_req($urandom_range(0, 1) ? fpp_pkg::REQ_FLUSH : REQ_UNKNOWN, $urandom(),
                  $urandom(), 1'($urandom_range(0, 1)));
      end
    end
    queue_req(fpp_pkg::REQ_TAKE, '0, '0, 1'b0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests and %0d result transfers in %0d cycles.",
             in_count, results_seen, cycle_count);
    $display("Seen: %0d full-pool rejects, %0d bad signatures, %0d blocks taken, %0d errors.",
             full_rejects, badsig_rejects, blocks_taken, mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
